[src/smalu_pkg.sv]
// Shared types and constants for the stack machine ALU.
`timescale 1ns / 1ps
package smalu_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int STAT_W = 2;
  localparam int DEPTH_OUT_W = 7;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_LOAD  = 4'd0;
  localparam logic [OP_W-1:0] OP_STORE = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_MOD   = 4'd6;
  localparam logic [OP_W-1:0] OP_LT    = 4'd7;
  localparam logic [OP_W-1:0] OP_GT    = 4'd8;
  localparam logic [OP_W-1:0] OP_EQ    = 4'd9;
  localparam logic [OP_W-1:0] OP_NOT   = 4'd10;
  localparam logic [OP_W-1:0] OP_JMP   = 4'd11;
  localparam logic [OP_W-1:0] OP_JT    = 4'd12;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd3;

  // What a stack cell does this cycle.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_DOWN,   // take the entry from the cell above (push side)
    CM_UP      // take the entry from the cell below (pop side)
  } cell_mode_t;

  // Shift control for the cell row: the top cell and all others.
  typedef struct packed {
    cell_mode_t top_mode;
    cell_mode_t rest_mode;
  } stk_ctrl_t;

endpackage

[src/stack_machine_alu.sv]
// Stack machine ALU: stack kept in a row of shift cells, sequenced per instruction.
// Result strobe (done) is registered and follows the S_EXEC state; jt passes through
// S_POP2 first (second pop shift), div and mod wait in S_DIV for the divider.
// busy is high while an instruction executes; a new instruction is taken only while
// idle, so one must finish before the next is accepted. The receiver cannot stall.
// Reset (rst, synchronous) empties the stack and idles the sequencer.
`timescale 1ns / 1ps
module stack_machine_alu #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [smalu_pkg::OP_W-1:0]        op,
  input  logic [smalu_pkg::DATA_W-1:0]      value,
  input  logic                              has_dest,
  output logic                              done,
  output logic [smalu_pkg::STAT_W-1:0]      status,
  output logic [smalu_pkg::DATA_W-1:0]      out_value,
  output logic                              jump_taken,
  output logic [smalu_pkg::DATA_W-1:0]      jump_target,
  output logic [smalu_pkg::DEPTH_OUT_W-1:0] stack_depth
);
  import smalu_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP2 = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]        state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] value_q;
  logic              dest_q;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  logic [DATA_W-1:0] wdata;
  stk_ctrl_t         ctrl;

  logic [DATA_W-1:0] top0, nxt1, nxt2;
  logic              has1, has2, has3, full;
  logic [DATA_W-1:0] top_val, second_val, third_val;
  logic [DATA_W-1:0] alu_r;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q, div_r;

  logic [STAT_W-1:0] st_c;
  logic [DATA_W-1:0] res_c, tgt_c;
  logic              taken_c, out_load, done_next;

  // stack cell row: cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above, below;
    cell_mode_t        mode;
    if (i == 0) begin : g_top
      assign above = wdata;
      assign mode  = ctrl.top_mode;
    end else begin : g_mid
      assign above = cell_q[i-1];
      assign mode  = ctrl.rest_mode;
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_lnk
      assign below = cell_q[i+1];
    end
    smalu_cell u_cell (
      .clk       (clk),
      .mode      (mode),
      .from_above(above),
      .from_below(below),
      .data      (cell_q[i])
    );
  end

  assign top0 = cell_q[0];
  assign nxt1 = cell_q[1];
  if (STACK_DEPTH > 2) begin : g_third
    assign nxt2 = cell_q[2];
  end else begin : g_nothird
    assign nxt2 = '0;
  end

  assign has1 = (sp != '0);
  assign has2 = (sp >= SP_W'(2));
  assign has3 = (sp >= SP_W'(3));
  assign full = (sp == SP_W'(STACK_DEPTH));

  assign top_val    = has1 ? top0 : '0;
  assign second_val = has2 ? nxt1 : '0;
  assign third_val  = has3 ? nxt2 : '0;

  // a = next entry, b = top
  always_comb begin
    case (op_q)
      OP_ADD:  alu_r = nxt1 + top0;
      OP_SUB:  alu_r = nxt1 - top0;
      OP_MUL:  alu_r = nxt1 * top0;
      OP_LT:   alu_r = DATA_W'(nxt1 < top0);
      OP_GT:   alu_r = DATA_W'(nxt1 > top0);
      OP_EQ:   alu_r = DATA_W'(nxt1 == top0);
      default: alu_r = '0;
    endcase
  end

  smalu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nxt1),
    .divisor  (top0),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    ctrl.top_mode  = CM_HOLD;
    ctrl.rest_mode = CM_HOLD;
    wdata          = alu_r;
    div_start      = 1'b0;
    st_c           = ST_OK;
    res_c          = top_val;
    taken_c        = 1'b0;
    tgt_c          = '0;
    out_load       = 1'b0;
    done_next      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (op_q)
          OP_LOAD: begin
            if (full) begin
              st_c = ST_OVER;
            end else begin
              ctrl.top_mode  = CM_DOWN;
              ctrl.rest_mode = CM_DOWN;
              wdata          = value_q;
              sp_next        = sp + SP_W'(1);
              res_c          = value_q;
            end
          end
          OP_STORE: begin
            if (!has1) begin
              st_c = ST_UNDER;
            end else begin
              ctrl.top_mode  = CM_UP;
              ctrl.rest_mode = CM_UP;
              sp_next        = sp - SP_W'(1);
              res_c          = dest_q ? top0 : '0;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_EQ: begin
            if (!has2) begin
              st_c = ST_UNDER;
            end else begin
              ctrl.top_mode  = CM_DOWN;
              ctrl.rest_mode = CM_UP;
              sp_next        = sp - SP_W'(1);
              res_c          = alu_r;
            end
          end
          OP_DIV, OP_MOD: begin
            if (!has2) begin
              st_c = ST_UNDER;
            end else if (top0 == '0) begin
              st_c = ST_DIVZ;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          OP_NOT: begin
            if (!has1) begin
              st_c = ST_UNDER;
            end else begin
              ctrl.top_mode = CM_DOWN;
              wdata         = DATA_W'(top0 == '0);
              res_c         = DATA_W'(top0 == '0);
            end
          end
          OP_JMP: begin
            if (!has1) begin
              st_c = ST_UNDER;
            end else begin
              ctrl.top_mode  = CM_UP;
              ctrl.rest_mode = CM_UP;
              sp_next        = sp - SP_W'(1);
              taken_c        = 1'b1;
              tgt_c          = top0;
              res_c          = second_val;
            end
          end
          OP_JT: begin
            if (!has2) begin
              st_c = ST_UNDER;
            end else begin
              // first pop now, second in S_POP2
              ctrl.top_mode  = CM_UP;
              ctrl.rest_mode = CM_UP;
              sp_next        = sp - SP_W'(2);
              taken_c        = (top0 != '0);
              tgt_c          = nxt1;
              res_c          = third_val;
              state_next     = S_POP2;
            end
          end
          default: ;
        endcase
        out_load  = (state_next != S_DIV);
        done_next = (state_next == S_IDLE);
      end
      S_POP2: begin
        ctrl.top_mode  = CM_UP;
        ctrl.rest_mode = CM_UP;
        state_next     = S_IDLE;
        done_next      = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          ctrl.top_mode  = CM_DOWN;
          ctrl.rest_mode = CM_UP;
          wdata          = (op_q == OP_MOD) ? div_r : div_q;
          res_c          = (op_q == OP_MOD) ? div_r : div_q;
          sp_next        = sp - SP_W'(1);
          out_load       = 1'b1;
          done_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q    <= op;
      value_q <= value;
      dest_q  <= has_dest;
    end
    if (out_load) begin
      status      <= st_c;
      out_value   <= res_c;
      jump_taken  <= taken_c;
      jump_target <= tgt_c;
      stack_depth <= DEPTH_OUT_W'(32'(sp_next));
    end
  end

endmodule

[src/smalu_cell.sv]
// One stack entry: holds a word and shifts toward the top or the bottom.
`timescale 1ns / 1ps
module smalu_cell (
  input  logic                        clk,
  input  smalu_pkg::cell_mode_t       mode,
  input  logic [smalu_pkg::DATA_W-1:0] from_above,
  input  logic [smalu_pkg::DATA_W-1:0] from_below,
  output logic [smalu_pkg::DATA_W-1:0] data
);
  import smalu_pkg::*;

  always_ff @(posedge clk) begin
    case (mode)
      CM_DOWN: data <= from_above;
      CM_UP:   data <= from_below;
      default: data <= data;
    endcase
  end

endmodule

[src/smalu_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module smalu_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [smalu_pkg::DATA_W-1:0] dividend,
  input  logic [smalu_pkg::DATA_W-1:0] divisor,
  output logic                         done,
  output logic [smalu_pkg::DATA_W-1:0] quotient,
  output logic [smalu_pkg::DATA_W-1:0] remainder
);
  import smalu_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] count;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      trial;

  // shifted partial remainder stays below twice the divisor
  assign trial = {remainder, quotient[DATA_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(DATA_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (running) begin
      if (!trial[DATA_W]) begin
        remainder <= trial[DATA_W-1:0];
        quotient  <= {quotient[DATA_W-2:0], 1'b1};
      end else begin
        remainder <= {remainder[DATA_W-2:0], quotient[DATA_W-1]};
        quotient  <= {quotient[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule
